// ----- design/hsl2rgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared constants, widths and helpers for the hsl to rgb converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  // full scale of every channel; the divide by it is a shift at this value
  localparam int FULL_SCALE = 128;

  // field width of every input and output port
  localparam int FIELD_W = 8;

  // width that holds 0..FULL_SCALE
  localparam int VAL_W = $clog2(FULL_SCALE + 1);

  // wide enough to compare a raw field against the full scale
  localparam int EXT_W = (FIELD_W > VAL_W) ? FIELD_W : VAL_W;

  // hue ramp breakpoints and channel shift
  localparam int HALF      = FULL_SCALE / 2;
  localparam int SIXTH     = FULL_SCALE / 6;
  localparam int TWO_THIRD = FULL_SCALE * 2 / 3;
  localparam int SHIFT     = FULL_SCALE / 3;

  // intermediate widths
  localparam int Q_W   = VAL_W + 1;           // levels q, p and span
  localparam int K_W   = VAL_W + 1;           // ramp slope factor
  localparam int MUL_W = VAL_W + Q_W;         // lightness product
  localparam int PR_W  = Q_W + K_W;           // ramp product
  localparam int T_W   = VAL_W + 1;           // shifted hue before wrap

  localparam int NUM_CH = 3;

  // saturate a raw field to the full scale
  function automatic logic [VAL_W-1:0] clamp_in(input logic [FIELD_W-1:0] v);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (ve > EXT_W'(FULL_SCALE)) begin
      return VAL_W'(FULL_SCALE);
    end
    return VAL_W'(ve);
  endfunction

endpackage

`default_nettype wire

// ----- design/hsl_to_rgb_converter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// an accepted item passes the stage 1 to 4 registers and the output register to the out_ ports
// throughput: one item per cycle while out_ is not stalled, five pipeline stages; the variable multiplies
// sit in stage 2 (lightness product) and stage 4 (one ramp product per channel)
// stalls propagate stage by stage; empty stages still fill while out_ is held
// reset: synchronous, active low, clears all stage valid bits only
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit
// Pipelined hsl to rgb color conversion on an integer scale of 0..FULL_SCALE.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_hue,
  input  wire logic [7:0] in_saturation,
  input  wire logic [7:0] in_lightness,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue
);

  localparam int VAL_W  = hsl2rgb_pkg::VAL_W;
  localparam int Q_W    = hsl2rgb_pkg::Q_W;
  localparam int K_W    = hsl2rgb_pkg::K_W;
  localparam int MUL_W  = hsl2rgb_pkg::MUL_W;
  localparam int PR_W   = hsl2rgb_pkg::PR_W;
  localparam int T_W    = hsl2rgb_pkg::T_W;
  localparam int NUM_CH = hsl2rgb_pkg::NUM_CH;
  localparam int FW     = hsl2rgb_pkg::FIELD_W;

  // hue ramp segment of one channel
  typedef enum logic [1:0] {
    RG_RISE,
    RG_HIGH,
    RG_FALL,
    RG_LOW
  } region_t;

  // ---------------- stage registers ----------------
  logic                 s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic                 s1_zero_r, s2_zero_r, s3_zero_r, s4_zero_r;
  logic [VAL_W-1:0]     s1_l_r, s2_l_r, s3_l_r, s4_l_r;
  logic [VAL_W-1:0]     s1_s_r, s2_s_r;
  region_t              s1_rg_r [NUM_CH];
  region_t              s2_rg_r [NUM_CH];
  region_t              s3_rg_r [NUM_CH];
  region_t              s4_rg_r [NUM_CH];
  logic [K_W-1:0]       s1_k_r [NUM_CH];
  logic [K_W-1:0]       s2_k_r [NUM_CH];
  logic [K_W-1:0]       s3_k_r [NUM_CH];
  logic [MUL_W-1:0]     s2_m_r;
  logic [Q_W-1:0]       s3_q_r, s3_p_r, s3_span_r;
  logic [Q_W-1:0]       s4_q_r, s4_p_r;
  logic [PR_W-1:0]      s4_prod_r [NUM_CH];
  logic [FW-1:0]        out_ch_r [NUM_CH];

  // ---------------- stall chain ----------------
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid_r || !out_stall;
  assign rdy4     = !s4_valid_r || rdy5;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  // ---------------- stage 1: clamp, hue shift, ramp segment ----------------
  logic [VAL_W-1:0] h_c, s_c, l_c;
  logic [VAL_W-1:0] t_c [NUM_CH];
  logic [T_W-1:0]   t_red_wide;
  region_t          rg_nxt [NUM_CH];
  logic [K_W-1:0]   k_nxt [NUM_CH];

  always_comb begin
    h_c = hsl2rgb_pkg::clamp_in(in_hue);
    s_c = hsl2rgb_pkg::clamp_in(in_saturation);
    l_c = hsl2rgb_pkg::clamp_in(in_lightness);

    // red: hue plus a third, wrapped once
    t_red_wide = T_W'(h_c) + T_W'(hsl2rgb_pkg::SHIFT);
    if (t_red_wide > T_W'(hsl2rgb_pkg::FULL_SCALE)) begin
      t_red_wide = t_red_wide - T_W'(hsl2rgb_pkg::FULL_SCALE);
    end
    t_c[0] = VAL_W'(t_red_wide);
    // green: hue as is
    t_c[1] = h_c;
    // blue: hue minus a third, wrapped once
    if (h_c < VAL_W'(hsl2rgb_pkg::SHIFT)) begin
      t_c[2] = VAL_W'(T_W'(h_c) + T_W'(hsl2rgb_pkg::FULL_SCALE)
                      - T_W'(hsl2rgb_pkg::SHIFT));
    end else begin
      t_c[2] = h_c - VAL_W'(hsl2rgb_pkg::SHIFT);
    end

    // segment and slope factor per channel
    for (int c = 0; c < NUM_CH; c++) begin
      if (t_c[c] < VAL_W'(hsl2rgb_pkg::SIXTH)) begin
        rg_nxt[c] = RG_RISE;
        k_nxt[c]  = K_W'((VAL_W + 3)'(t_c[c]) * (VAL_W + 3)'(6));
      end else if (t_c[c] < VAL_W'(hsl2rgb_pkg::HALF)) begin
        rg_nxt[c] = RG_HIGH;
        k_nxt[c]  = '0;
      end else if (t_c[c] < VAL_W'(hsl2rgb_pkg::TWO_THIRD)) begin
        rg_nxt[c] = RG_FALL;
        k_nxt[c]  = K_W'((VAL_W + 3)'(VAL_W'(hsl2rgb_pkg::TWO_THIRD) - t_c[c])
                         * (VAL_W + 3)'(6));
      end else begin
        rg_nxt[c] = RG_LOW;
        k_nxt[c]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_valid;
    end
    if (rdy1) begin
      s1_zero_r <= (s_c == '0);
      s1_l_r    <= l_c;
      s1_s_r    <= s_c;
      for (int c = 0; c < NUM_CH; c++) begin
        s1_rg_r[c] <= rg_nxt[c];
        s1_k_r[c]  <= k_nxt[c];
      end
    end
  end

  // ---------------- stage 2: lightness product ----------------
  logic [Q_W-1:0]   mul_op;
  logic [MUL_W-1:0] m_nxt;

  always_comb begin
    if (s1_l_r < VAL_W'(hsl2rgb_pkg::HALF)) begin
      mul_op = Q_W'(hsl2rgb_pkg::FULL_SCALE) + Q_W'(s1_s_r);
    end else begin
      mul_op = Q_W'(s1_s_r);
    end
    m_nxt = MUL_W'(s1_l_r) * MUL_W'(mul_op);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
    if (rdy2) begin
      s2_zero_r <= s1_zero_r;
      s2_l_r    <= s1_l_r;
      s2_s_r    <= s1_s_r;
      s2_m_r    <= m_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        s2_rg_r[c] <= s1_rg_r[c];
        s2_k_r[c]  <= s1_k_r[c];
      end
    end
  end

  // ---------------- stage 3: upper and lower levels ----------------
  logic [Q_W-1:0] rnd_m, q_nxt, p_nxt, twol;

  always_comb begin
    rnd_m = Q_W'((s2_m_r + MUL_W'(hsl2rgb_pkg::HALF)) / hsl2rgb_pkg::FULL_SCALE);
    twol  = {s2_l_r, 1'b0};
    if (s2_l_r < VAL_W'(hsl2rgb_pkg::HALF)) begin
      q_nxt = rnd_m;
    end else begin
      q_nxt = Q_W'(s2_l_r) + Q_W'(s2_s_r) - rnd_m;
    end
    if (q_nxt > twol) begin
      q_nxt = twol;
    end
    if (q_nxt < Q_W'(s2_l_r)) begin
      q_nxt = Q_W'(s2_l_r);
    end
    p_nxt = twol - q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (rdy3) begin
      s3_valid_r <= s2_valid_r;
    end
    if (rdy3) begin
      s3_zero_r <= s2_zero_r;
      s3_l_r    <= s2_l_r;
      s3_q_r    <= q_nxt;
      s3_p_r    <= p_nxt;
      s3_span_r <= q_nxt - p_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        s3_rg_r[c] <= s2_rg_r[c];
        s3_k_r[c]  <= s2_k_r[c];
      end
    end
  end

  // ---------------- stage 4: ramp products, one per channel ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (rdy4) begin
      s4_valid_r <= s3_valid_r;
    end
    if (rdy4) begin
      s4_zero_r <= s3_zero_r;
      s4_l_r    <= s3_l_r;
      s4_q_r    <= s3_q_r;
      s4_p_r    <= s3_p_r;
      for (int c = 0; c < NUM_CH; c++) begin
        s4_rg_r[c]   <= s3_rg_r[c];
        s4_prod_r[c] <= PR_W'(s3_span_r) * PR_W'(s3_k_r[c]);
      end
    end
  end

  // ---------------- stage 5: round, add base, select segment ----------------
  logic [Q_W:0]  ramp_val [NUM_CH];
  logic [FW-1:0] ch_nxt [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ramp_val[c] = (Q_W + 1)'(s4_p_r)
                  + (Q_W + 1)'((s4_prod_r[c] + PR_W'(hsl2rgb_pkg::HALF))
                               / hsl2rgb_pkg::FULL_SCALE);
      if (s4_zero_r) begin
        ch_nxt[c] = FW'(s4_l_r);
      end else begin
        case (s4_rg_r[c])
          RG_RISE: ch_nxt[c] = FW'(ramp_val[c]);
          RG_HIGH: ch_nxt[c] = FW'(s4_q_r);
          RG_FALL: ch_nxt[c] = FW'(ramp_val[c]);
          RG_LOW:  ch_nxt[c] = FW'(s4_p_r);
          default: ch_nxt[c] = FW'(s4_p_r);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy5) begin
      out_valid_r <= s4_valid_r;
    end
    if (rdy5) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_ch_r[c] <= ch_nxt[c];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_ch_r[0];
  assign out_green = out_ch_r[1];
  assign out_blue  = out_ch_r[2];

  // ---------------- assertions ----------------
  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  // an accepted item always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted item lost at stage 1");

  // the lower level never exceeds the upper one
  a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_p_r <= s3_q_r))
    else $error("lower level above upper level");

  // a full pipe behind a held output must stall the input
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s4_valid_r && s3_valid_r && s2_valid_r
     && s1_valid_r) |-> in_stall)
    else $error("input taken while pipeline full");

  // a result channel never exceeds the full scale
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_ch_r[0] <= FW'(hsl2rgb_pkg::FULL_SCALE))
                  && (out_ch_r[1] <= FW'(hsl2rgb_pkg::FULL_SCALE))
                  && (out_ch_r[2] <= FW'(hsl2rgb_pkg::FULL_SCALE))))
    else $error("result above full scale");

endmodule

`default_nettype wire
